>>> hw/rtl/utt_pkg.sv
// Shared types and constants for the UTF-16 to UTF-8 transcoder.
package utt_pkg;

	// Byte order marks as read big-endian from the first byte pair
	localparam logic [15:0] MARK_LE = 16'hfffe;
	localparam logic [15:0] MARK_BE = 16'hfeff;

	// Queue between the front and back parts
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// One classified request for the back part: a code point to encode,
	// its UTF-8 length (zero for a bare end marker) and end-of-field status
	typedef struct packed {
		logic [20:0] cp;
		logic [2:0]  len;
		logic        last;
		logic        err;
	} utt_entry_t;

endpackage

>>> hw/rtl/utt_front.sv
// Front part: pairs bytes, detects the byte order mark, joins surrogates.
module utt_front
	import utt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] in_byte,
	input  logic       is_last,
	output logic       push,
	output utt_entry_t entry
);

	logic       at_start_q;
	logic       held_valid_q;
	logic       little_endian_q;
	logic       high_pending_q;
	logic       failed_q;
	logic [7:0] held_byte_q;
	logic [9:0] high_half_q;

	logic [15:0] be;
	logic [15:0] u;
	logic        is_mark;
	logic        do_unit;
	logic        is_low;
	logic        is_high;
	logic        n_high_pending;
	logic        n_failed;
	logic        n_set_half;
	logic        emit_en;
	logic [20:0] emit_cp;
	logic [2:0]  emit_len;
	logic        fail_final;

	// Form the code unit from the held byte and the new byte
	assign be      = {held_byte_q, in_byte};
	assign is_mark = at_start_q && ((be == MARK_LE) || (be == MARK_BE));
	assign u       = (little_endian_q && !at_start_q) ? {in_byte, held_byte_q} : be;
	assign do_unit = held_valid_q && !is_mark;
	assign is_low  = (u[15:10] == 6'b110111);
	assign is_high = (u[15:10] == 6'b110110);

	// Classify the unit: surrogate tracking and code point selection
	always_comb begin
		n_high_pending = high_pending_q;
		n_failed       = failed_q;
		n_set_half     = 1'b0;
		emit_en        = 1'b0;
		emit_cp        = {5'd0, u};
		if (do_unit) begin
			if (high_pending_q) begin
				n_high_pending = 1'b0;
				if (is_low) begin
					emit_cp = 21'h10000 + {1'b0, high_half_q, u[9:0]};
					emit_en = !failed_q;
				end else begin
					n_failed = 1'b1;
				end
			end else if (u == 16'd0) begin
				n_failed = failed_q;
			end else if (is_high) begin
				n_high_pending = 1'b1;
				n_set_half     = 1'b1;
			end else if (is_low) begin
				n_failed = 1'b1;
			end else begin
				emit_en = !failed_q;
			end
		end
	end

	// Size the UTF-8 encoding
	always_comb begin
		if (emit_cp[20:7] == 14'd0) begin
			emit_len = 3'd1;
		end else if (emit_cp[20:11] == 10'd0) begin
			emit_len = 3'd2;
		end else if (emit_cp[20:16] == 5'd0) begin
			emit_len = 3'd3;
		end else begin
			emit_len = 3'd4;
		end
	end

	// Build the request for the queue
	assign fail_final = n_failed || n_high_pending;
	assign push       = accept && (emit_en || is_last);
	always_comb begin
		entry.cp   = emit_cp;
		entry.last = is_last;
		entry.err  = is_last && fail_final;
		entry.len  = (emit_en && !(is_last && fail_final)) ? emit_len : 3'd0;
	end

	// Advance the field state; drop back to reset after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q      <= 1'b1;
			held_valid_q    <= 1'b0;
			little_endian_q <= 1'b0;
			high_pending_q  <= 1'b0;
			failed_q        <= 1'b0;
		end else if (accept) begin
			if (is_last) begin
				at_start_q      <= 1'b1;
				held_valid_q    <= 1'b0;
				little_endian_q <= 1'b0;
				high_pending_q  <= 1'b0;
				failed_q        <= 1'b0;
			end else begin
				held_valid_q   <= !held_valid_q;
				high_pending_q <= n_high_pending;
				failed_q       <= n_failed;
				if (held_valid_q) begin
					at_start_q <= 1'b0;
					if (at_start_q && (be == MARK_LE)) begin
						little_endian_q <= 1'b1;
					end
				end
			end
		end
	end

	// Hold the first byte of a pair and the high surrogate bits
	always_ff @(posedge clk) begin
		if (accept && !held_valid_q) begin
			held_byte_q <= in_byte;
		end
		if (accept && n_set_half) begin
			high_half_q <= u[9:0];
		end
	end

endmodule

>>> hw/rtl/utt_queue.sv
// Short request queue between the front and back parts.
module utt_queue
	import utt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  utt_entry_t wr_entry,
	input  logic       pop,
	output utt_entry_t head,
	output logic       not_empty,
	output logic       full
);

	utt_entry_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head      = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));

	// Store a request
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/utt_back.sv
// Back part: encodes a queued code point to UTF-8, one byte per cycle unless stalled.
module utt_back
	import utt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  utt_entry_t head,
	input  logic       not_empty,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       end_of_field,
	output logic       error
);

	logic       valid_q;
	logic [1:0] idx_q;
	logic [7:0] byte_q;
	logic       byte_valid_q;
	logic       eof_q;
	logic       err_q;

	logic       take;
	logic [2:0] nbytes;
	logic [2:0] last_idx;
	logic       final_byte;
	logic [1:0] from_end;
	logic [5:0] seg;
	logic [7:0] byte_sel;

	assign take       = not_empty && (!valid_q || !out_stall);
	assign nbytes     = (head.len == 3'd0) ? 3'd1 : head.len;
	assign last_idx   = nbytes - 3'd1;
	assign final_byte = (idx_q == last_idx[1:0]);
	assign from_end   = last_idx[1:0] - idx_q;
	assign pop        = take && final_byte;

	// Pick the six payload bits of a continuation byte
	always_comb begin
		case (from_end)
			2'd0:    seg = head.cp[5:0];
			2'd1:    seg = head.cp[11:6];
			2'd2:    seg = head.cp[17:12];
			default: seg = {3'd0, head.cp[20:18]};
		endcase
	end

	// Select the lead byte by length, or a continuation byte
	always_comb begin
		if (idx_q == 2'd0) begin
			case (head.len)
				3'd1:    byte_sel = {1'b0, head.cp[6:0]};
				3'd2:    byte_sel = {3'b110, head.cp[10:6]};
				3'd3:    byte_sel = {4'b1110, head.cp[15:12]};
				3'd4:    byte_sel = {5'b11110, head.cp[20:18]};
				default: byte_sel = 8'h00;
			endcase
		end else begin
			byte_sel = {2'b10, seg};
		end
	end

	// Advance the output valid and byte index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (take) begin
				valid_q <= 1'b1;
				idx_q   <= final_byte ? 2'd0 : idx_q + 2'd1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Load the output register
	always_ff @(posedge clk) begin
		if (take) begin
			byte_q       <= byte_sel;
			byte_valid_q <= (head.len != 3'd0);
			eof_q        <= head.last && final_byte;
			err_q        <= head.err;
		end
	end

	assign out_valid    = valid_q;
	assign out_byte     = byte_q;
	assign byte_valid   = byte_valid_q;
	assign end_of_field = eof_q;
	assign error        = err_q;

endmodule

>>> hw/rtl/utf16_to_utf8_transcoder.sv
// UTF-16 to UTF-8 transcoder top level: front part, request queue, back part.
//
// Input channel: one raw byte of a UTF-16 field per request (in_byte),
// with is_last on the final byte. A leading FF FE or FE FF pair picks the
// byte order and is dropped; without one the field is read big-endian.
// Output channel: one UTF-8 byte per request (out_byte, byte_valid = 1),
// or a bare end marker (byte_valid = 0). end_of_field marks the final
// request of each field; error is set on that marker when an unpaired
// surrogate was seen, and data bytes after that surrogate are suppressed.
// Both channels use valid/stall; a request moves when valid is high and
// stall is low.
// With the queue and output idle, the first UTF-8 byte of a code unit is
// written into the queue when its closing input byte is accepted, then
// loaded into the output register. The front takes one byte per cycle
// while in_stall is low; the back gives one UTF-8 byte per cycle while
// out_stall is low. A four-entry queue between them absorbs the extra
// bytes of long code points; in_stall rises only while the queue is full.
// While out_stall is high the output register holds and the queue fills.
// Reset clears the field state, the queue and the output valid.
module utf16_to_utf8_transcoder
	import utt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       is_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       end_of_field,
	output logic       error
);

	logic       accept;
	logic       push;
	logic       pop;
	logic       not_empty;
	logic       full;
	utt_entry_t wr_entry;
	utt_entry_t head;

	assign in_stall = full;
	assign accept   = in_valid && !in_stall;

	utt_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_byte (in_byte),
		.is_last (is_last),
		.push    (push),
		.entry   (wr_entry)
	);

	utt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_entry  (wr_entry),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.full      (full)
	);

	utt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.not_empty    (not_empty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.byte_valid   (byte_valid),
		.end_of_field (end_of_field),
		.error        (error)
	);

	// Never write into a full queue
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("request pushed into full queue");

	// A bare marker only closes a field
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !byte_valid) |-> end_of_field)
		else $error("bare marker without end of field");

	// Error is reported only on a bare end marker
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error) |-> (!byte_valid && end_of_field))
		else $error("error flag on a data byte");

endmodule

>>> verif/utf8_stream_checker.sv
// Checker for the UTF-16 to UTF-8 transcoder: predicts UTF-8 requests and compares them.
`timescale 1ns / 100ps

module utf8_stream_checker
	import utt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       is_last,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] out_byte,
	input  logic       byte_valid,
	input  logic       end_of_field,
	input  logic       error,
	output int         failures,
	output int         pending,
	output int         taken
);

	localparam logic [5:0]  HIGH_TAG = 6'b110110;
	localparam logic [5:0]  LOW_TAG  = 6'b110111;
	localparam logic [20:0] CP_MAX   = 21'h10ffff;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       eof;
		logic       err;
	} utf8_byte_t;

	utf8_byte_t utf8_expected[$];
	utf8_byte_t step_out[4];
	utf8_byte_t want;
	int         step_n;

	// Field state of the transcoder
	logic       awaiting_pair;
	logic [7:0] first_byte;
	logic       first_held;
	logic       swap_bytes;
	logic [9:0] high_bits;
	logic       high_open;
	logic       field_bad;

	function void clear_field();
		awaiting_pair = 1'b1;
		first_byte    = 8'h00;
		first_held    = 1'b0;
		swap_bytes    = 1'b0;
		high_bits     = 10'h000;
		high_open     = 1'b0;
		field_bad     = 1'b0;
	endfunction

	function void put_byte(logic [7:0] b);
		step_out[step_n] = '{data: b, valid: 1'b1, eof: 1'b0, err: 1'b0};
		step_n++;
	endfunction

	// Encode one code point as 1 to 4 UTF-8 bytes; nothing once the field failed or above CP_MAX
	function void encode_cp(logic [20:0] cp);
		if (field_bad || cp > CP_MAX)
			return;
		if (cp < 21'h80) begin
			put_byte(cp[7:0]);
		end else if (cp < 21'h800) begin
			put_byte({3'b110, cp[10:6]});
			put_byte({2'b10, cp[5:0]});
		end else if (cp < 21'h10000) begin
			put_byte({4'b1110, cp[15:12]});
			put_byte({2'b10, cp[11:6]});
			put_byte({2'b10, cp[5:0]});
		end else begin
			put_byte({5'b11110, cp[20:18]});
			put_byte({2'b10, cp[17:12]});
			put_byte({2'b10, cp[11:6]});
			put_byte({2'b10, cp[5:0]});
		end
	endfunction

	// Join surrogates, drop separators, flag unpaired halves
	function void take_unit(logic [15:0] u);
		logic is_low;
		logic is_high;
		is_low  = (u[15:10] == LOW_TAG);
		is_high = (u[15:10] == HIGH_TAG);
		if (high_open) begin
			high_open = 1'b0;
			if (is_low)
				encode_cp(21'h10000 + {1'b0, high_bits, u[9:0]});
			else
				field_bad = 1'b1;
		end else if (u == 16'h0000) begin
			// separator, dropped
		end else if (is_high) begin
			high_open = 1'b1;
			high_bits = u[9:0];
		end else if (is_low) begin
			field_bad = 1'b1;
		end else begin
			encode_cp({5'b0, u});
		end
	endfunction

	// Work out the UTF-8 requests caused by one accepted input byte
	function void transcode_byte(logic [7:0] b, logic last);
		step_n = 0;
		if (!first_held) begin
			first_byte = b;
			first_held = 1'b1;
		end else begin
			first_held = 1'b0;
			if (awaiting_pair) begin
				awaiting_pair = 1'b0;
				if ({first_byte, b} == MARK_LE)
					swap_bytes = 1'b1;
				else if ({first_byte, b} != MARK_BE)
					take_unit({first_byte, b});
			end else begin
				take_unit(swap_bytes ? {b, first_byte} : {first_byte, b});
			end
		end
		if (last) begin
			if (high_open)
				field_bad = 1'b1;
			if (field_bad)
				step_n = 0;
			if (step_n == 0) begin
				step_out[0] = '{data: 8'h00, valid: 1'b0, eof: 1'b1, err: field_bad};
				step_n = 1;
			end else begin
				step_out[step_n - 1].eof = 1'b1;
			end
			clear_field();
		end
		for (int i = 0; i < step_n; i++)
			utf8_expected.insert(utf8_expected.size(), step_out[i]);
	endfunction

	// Predict on each accepted request, then compare each output request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_field();
			utf8_expected.delete();
			failures = 0;
			pending  = 0;
			taken    = 0;
		end else begin
			if (in_valid && !in_stall) begin
				transcode_byte(in_byte, is_last);
				taken++;
			end
			if (out_valid && !out_stall) begin
				if (utf8_expected.size() == 0) begin
					$error("unexpected output request: out_byte %02h byte_valid %0b",
						out_byte, byte_valid);
					failures++;
				end else begin
					want = utf8_expected.pop_front();
					if (out_byte !== want.data) begin
						$error("out_byte: expected %02h, got %02h", want.data, out_byte);
						failures++;
					end
					if (byte_valid !== want.valid) begin
						$error("byte_valid: expected %0b, got %0b", want.valid, byte_valid);
						failures++;
					end
					if (end_of_field !== want.eof) begin
						$error("end_of_field: expected %0b, got %0b", want.eof, end_of_field);
						failures++;
					end
					if (error !== want.err) begin
						$error("error: expected %0b, got %0b", want.err, error);
						failures++;
					end
				end
			end
			pending = utf8_expected.size();
		end
	end

endmodule

>>> verif/testbench.sv
// Top of the transcoder testbench: clock, reset, field stimulus, receiver and verdict.
`timescale 1ns / 100ps

module testbench;
	import utt_pkg::*;

	localparam logic [15:0] HIGH_BASE = 16'hd800;
	localparam logic [15:0] LOW_BASE  = 16'hdc00;
	localparam int          RANDOM_BYTES = 100;
	localparam int          HOLD_CYCLES  = 80;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_byte;
	logic       is_last;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       end_of_field;
	logic       error;
	int         failures;
	int         pending;
	int         taken;

	logic       quiet;
	logic       hold_req;
	logic [7:0] field_q[$];

	utf16_to_utf8_transcoder u_top (.*);

	utf8_stream_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("[utf16_to_utf8_transcoder] ERROR");
		$finish;
	end

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	// Offer one byte and hold it until it is taken
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		int target;
		gap = 0;
		if (!quiet && $urandom_range(0, 3) == 0)
			gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		is_last  <= last;
		target = taken + 1;
		do @(negedge clk); while (taken != target);
	endtask

	task automatic send_field();
		for (int i = 0; i < field_q.size(); i++)
			send_byte(field_q[i], i == field_q.size() - 1);
	endtask

	// Append one byte to the field being built
	function automatic void add_byte(input logic [7:0] b);
		field_q.insert(field_q.size(), b);
	endfunction

	task automatic push_unit(input logic [15:0] u, input logic le);
		if (le) begin
			add_byte(u[7:0]);
			add_byte(u[15:8]);
		end else begin
			add_byte(u[15:8]);
			add_byte(u[7:0]);
		end
	endtask

	// Build a field: optional mark, mostly well-formed units, some noise
	task automatic build_random_field();
		int         mark;
		int         units;
		logic       le;
		logic [15:0] u;
		field_q.delete();
		mark = $urandom_range(0, 3);
		le = (mark == 1);
		if (mark == 1) begin
			add_byte(MARK_LE[15:8]);
			add_byte(MARK_LE[7:0]);
		end else if (mark == 2) begin
			add_byte(MARK_BE[15:8]);
			add_byte(MARK_BE[7:0]);
		end
		units = $urandom_range(1, 5);
		repeat (units) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5: push_unit(16'($urandom_range(1, 'h7f)), le);
				6, 7, 8:          push_unit(16'($urandom_range('h80, 'h7ff)), le);
				9, 10, 11: begin
					u = 16'($urandom_range('h800, 'hffff));
					// move surrogate values into the private-use area
					if (u[15:11] == 5'b11011)
						u[15:11] = 5'b11100;
					push_unit(u, le);
				end
				12, 13, 14: begin
					push_unit(HIGH_BASE | 16'($urandom_range(0, 'h3ff)), le);
					push_unit(LOW_BASE | 16'($urandom_range(0, 'h3ff)), le);
				end
				15: push_unit(16'h0000, le);
				16: push_unit(LOW_BASE | 16'($urandom_range(0, 'h3ff)), le);
				17: begin
					push_unit(HIGH_BASE | 16'($urandom_range(0, 'h3ff)), le);
					push_unit(16'($urandom_range(0, 'h7f)), le);
				end
				18: push_unit(16'($urandom_range(0, 'hffff)), le);
				default: push_unit(HIGH_BASE | 16'($urandom_range(0, 'h3ff)), le);
			endcase
		end
		// odd trailing byte
		if ($urandom_range(0, 7) == 0)
			add_byte(8'($urandom_range(0, 255)));
	endtask

	// Receiver: random stalls, one long hold on request
	initial begin
		int stall_left;
		out_stall  = 1'b0;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap() - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Stimulus and verdict
	initial begin
		int random_bytes;
		int nfield;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_byte  = 8'h00;
		is_last  = 1'b0;
		quiet    = 1'b0;
		hold_req = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// little-endian mark, then a four-byte code point
		field_q = '{MARK_LE[15:8], MARK_LE[7:0], 8'h3d, 8'hd8, 8'h00, 8'hde};
		send_field();
		// no mark: separator, largest two-byte and three-byte values
		field_q = '{8'h00, 8'h00, 8'h07, 8'hff, 8'hff, 8'hff};
		send_field();
		// big-endian mark, highest code point
		field_q = '{MARK_BE[15:8], MARK_BE[7:0], 8'hdb, 8'hff, 8'hdf, 8'hff};
		send_field();
		// lone low surrogate suppresses the rest of the field
		field_q = '{8'hdc, 8'h00, 8'h00, 8'h7f};
		send_field();
		// high surrogate left open at the end
		field_q = '{8'hd8, 8'h00};
		send_field();
		// single odd byte: bare end marker
		field_q = '{8'h41};
		send_field();

		random_bytes = 0;
		nfield = 0;
		while (random_bytes < RANDOM_BYTES) begin
			quiet = (nfield % 6) >= 4;
			// long receiver hold while the sender keeps offering
			if (nfield == 4)
				hold_req = 1'b1;
			// pause until every expected request has come out
			if (nfield == 9) begin
				in_valid <= 1'b0;
				@(negedge clk);
				while (pending != 0) @(negedge clk);
			end
			build_random_field();
			send_field();
			random_bytes += field_q.size();
			nfield++;
		end
		in_valid <= 1'b0;
		quiet = 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (failures == 0)
			$display("[utf16_to_utf8_transcoder] OK");
		else
			$display("[utf16_to_utf8_transcoder] ERROR");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/utt_pkg.sv
hw/rtl/utt_front.sv
hw/rtl/utt_queue.sv
hw/rtl/utt_back.sv
hw/rtl/utf16_to_utf8_transcoder.sv
verif/utf8_stream_checker.sv
verif/testbench.sv
